/* src/implicit_bst_search_with_limit_core_defines.svh */
// Assertion helpers for the checker file.
`ifndef IMPLICIT_BST_SEARCH_WITH_LIMIT_CORE_DEFINES_SVH
`define IMPLICIT_BST_SEARCH_WITH_LIMIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IBST_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IBST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ibst_pkg.sv */
package ibst_pkg;

  // Fixed field widths
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned VAL_W       = 31;
  localparam int unsigned OUTC_W      = 2;
  localparam int unsigned LIMIT_W     = 4;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 16;

  // Register reset values
  localparam logic [IDX_W-1:0]   NODES_RESET = 10'd1023;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd11;

  // Register indexes
  localparam logic CFG_NODES_IN_USE = 1'b0;
  localparam logic CFG_STEP_LIMIT   = 1'b1;

  // Request kinds
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Outcome codes
  localparam logic [OUTC_W-1:0] OUT_FOUND = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_EMPTY = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  found_index;
    logic [OUTC_W-1:0] outcome;
  } res_t;

endpackage

/* src/ibst_ram.sv */
module ibst_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 1023,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/implicit_bst_search_with_limit_core.sv */
// Implicit binary search tree lookup engine.
// Input stream (s_*): s_tuser selects the request, 0 writes one node and
// 1 searches for a key. A write gives no result.
// A search walks from the root, examining one level per cycle from the
// node memory, and gives one result on the output stream (m_*).
// The walk is bound by the single read port of the node memory: one
// level per cycle.
// s_tready is low while a search walks and until its result is registered.
// Config port: cfg_we writes register cfg_index (0 nodes_in_use,
// 1 step_limit); write only while no search is in flight.
// Reset: the node memory is cleared one entry per cycle, with s_tready
// low; config writes are taken during the pass.
// Output stall: the result holds in the output register; a request can
// still be accepted, and a later search result waits until the output
// register empties.
module implicit_bst_search_with_limit_core #(
  parameter int unsigned TREE_SLOTS = 1023,
  parameter int unsigned MAX_DEPTH  = 11
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // node_index[9:0], node_value[40:10], search_key[71:41]
  input  logic [ibst_pkg::IN_TDATA_W-1:0]    s_tdata,
  // req_type[0]
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // found[0], found_index[10:1], outcome[12:11], zero[15:13]
  output logic [ibst_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [ibst_pkg::IDX_W-1:0]         cfg_data
);

  localparam int unsigned AW = (TREE_SLOTS > 1) ? $clog2(TREE_SLOTS) : 1;
  localparam int unsigned IW = AW + 2;

  ibst_pkg::state_t state, state_next;

  logic [ibst_pkg::IDX_W-1:0]   nodes_in_use;
  logic [ibst_pkg::LIMIT_W-1:0] step_limit;
  logic [AW-1:0]                clr_addr;
  logic [IW-1:0]                idx;
  logic [ibst_pkg::LIMIT_W-1:0] steps_left;
  logic [ibst_pkg::VAL_W-1:0]   key;
  ibst_pkg::res_t               res, res_next;

  logic                         s_acc;
  logic [ibst_pkg::IDX_W-1:0]   in_index;
  logic [ibst_pkg::VAL_W-1:0]   in_value;
  logic [ibst_pkg::VAL_W-1:0]   in_key;

  logic                         wr_en, rd_en, out_load;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic [ibst_pkg::VAL_W-1:0]   wr_data, rd_data;

  logic [IW-1:0]                size_w, child;
  logic                         unlimited, oob, node_empty, at_limit, hit;
  logic                         go_left, child_ok, walk_done;

  // Unpack the request
  assign s_acc    = s_tvalid && s_tready;
  assign in_index = s_tdata[9:0];
  assign in_value = s_tdata[40:10];
  assign in_key   = s_tdata[71:41];

  // Node memory
  ibst_ram #(
    .WIDTH (ibst_pkg::VAL_W),
    .DEPTH (TREE_SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Evaluate the node just read
  always_comb begin
    size_w     = (32'(nodes_in_use) < TREE_SLOTS) ? IW'(nodes_in_use) : IW'(TREE_SLOTS);
    unlimited  = 32'(step_limit) >= MAX_DEPTH;
    oob        = idx >= size_w;
    node_empty = oob || (rd_data == '0);
    at_limit   = !unlimited && (steps_left == '0);
    hit        = rd_data == key;
    go_left    = rd_data > key;
    child      = {idx[IW-2:0], 1'b0} + (go_left ? IW'(1) : IW'(2));
    child_ok   = 32'(child) < TREE_SLOTS;
    walk_done  = node_empty || at_limit || hit;
  end

  // Build the result of a finished walk
  always_comb begin
    if (node_empty) begin
      res_next = '{found: 1'b0, found_index: '0, outcome: ibst_pkg::OUT_EMPTY};
    end else if (at_limit) begin
      res_next = '{found: 1'b0, found_index: '0, outcome: ibst_pkg::OUT_LIMIT};
    end else begin
      res_next = '{found: 1'b1, found_index: ibst_pkg::IDX_W'(idx),
                   outcome: ibst_pkg::OUT_FOUND};
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ibst_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(TREE_SLOTS - 1)) state_next = ibst_pkg::ST_IDLE;
      end
      ibst_pkg::ST_IDLE: begin
        if (s_acc && (s_tuser == ibst_pkg::REQ_SEARCH)) state_next = ibst_pkg::ST_WALK;
      end
      ibst_pkg::ST_WALK: begin
        if (walk_done) state_next = ibst_pkg::ST_DONE;
      end
      ibst_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = ibst_pkg::ST_IDLE;
      end
      default: state_next = ibst_pkg::ST_CLEAR;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = clr_addr;
    wr_data  = '0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    out_load = 1'b0;
    case (state)
      ibst_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ibst_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_acc && (s_tuser == ibst_pkg::REQ_WRITE) && (32'(in_index) < TREE_SLOTS)) begin
          wr_en   = 1'b1;
          wr_addr = AW'(in_index);
          wr_data = in_value;
        end
        if (s_acc && (s_tuser == ibst_pkg::REQ_SEARCH)) begin
          rd_en = 1'b1;
        end
      end
      ibst_pkg::ST_WALK: begin
        if (!walk_done) begin
          rd_en   = 1'b1;
          rd_addr = child_ok ? child[AW-1:0] : '0;
        end
      end
      ibst_pkg::ST_DONE: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ibst_pkg::ST_CLEAR;
      clr_addr     <= '0;
      nodes_in_use <= ibst_pkg::NODES_RESET;
      step_limit   <= ibst_pkg::LIMIT_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ibst_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          ibst_pkg::CFG_NODES_IN_USE: nodes_in_use <= cfg_data;
          ibst_pkg::CFG_STEP_LIMIT:   step_limit   <= cfg_data[ibst_pkg::LIMIT_W-1:0];
          default:                    step_limit   <= step_limit;
        endcase
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Walk registers and output payload
  always_ff @(posedge clk) begin
    if ((state == ibst_pkg::ST_IDLE) && s_acc && (s_tuser == ibst_pkg::REQ_SEARCH)) begin
      idx        <= '0;
      steps_left <= step_limit;
      key        <= in_key;
    end
    if (state == ibst_pkg::ST_WALK) begin
      if (walk_done) begin
        res <= res_next;
      end else begin
        idx <= child;
        if (!unlimited) steps_left <= steps_left - ibst_pkg::LIMIT_W'(1);
      end
    end
    if (out_load) begin
      m_tdata <= {3'b000, res.outcome, res.found_index, res.found};
    end
  end

endmodule

/* src/ibst_checker.sv */
`include "implicit_bst_search_with_limit_core_defines.svh"

module ibst_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ibst_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // A hit always reports the found outcome
  `IBST_ASSERT_IMPL(a_found_code, clk, rst, m_tvalid && m_tdata[0], m_tdata[12:11] == ibst_pkg::OUT_FOUND, "hit without found outcome")

  // A miss carries a zero index and a miss outcome
  `IBST_ASSERT_IMPL(a_miss_fields, clk, rst, m_tvalid && !m_tdata[0], (m_tdata[10:1] == '0) && ((m_tdata[12:11] == ibst_pkg::OUT_EMPTY) || (m_tdata[12:11] == ibst_pkg::OUT_LIMIT)), "bad miss result")

  // A search request blocks the input while it walks
  `IBST_ASSERT_NEXT(a_search_busy, clk, rst, s_tvalid && s_tready && (s_tuser == ibst_pkg::REQ_SEARCH), !s_tready, "input ready during search")

  // A stalled result holds
  `IBST_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

endmodule

bind implicit_bst_search_with_limit_core ibst_checker u_ibst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
